[hw/rtl/pl0_lexical_scanner_top_macros.svh]
// Assertion macros for the PL/0 scanner RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef PL0_LEXICAL_SCANNER_TOP_MACROS_SVH
`define PL0_LEXICAL_SCANNER_TOP_MACROS_SVH

// Check a property on every edge outside reset.
`define PL0_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define PL0_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/pl0lex_pkg.sv]
// Shared types, token codes and keyword table for the PL/0 scanner.
// No dependencies; every RTL module file refers to it by scoped names.
package pl0lex_pkg;

  // Identifier storage
  localparam int MAX_ID_CHARS = 8;
  localparam int KW_COUNT     = 15;
  localparam int RQ_DEPTH     = 4;

  // Token codes
  localparam logic [5:0] TK_NONE     = 6'd0;
  localparam logic [5:0] TK_NUMBER   = 6'd1;
  localparam logic [5:0] TK_IDENT    = 6'd2;
  localparam logic [5:0] TK_KW_FIRST = 6'd3;
  localparam logic [5:0] TK_PLUS     = 6'd18;
  localparam logic [5:0] TK_MINUS    = 6'd19;
  localparam logic [5:0] TK_TIMES    = 6'd20;
  localparam logic [5:0] TK_SLASH    = 6'd21;
  localparam logic [5:0] TK_PERCENT  = 6'd22;
  localparam logic [5:0] TK_EQL      = 6'd23;
  localparam logic [5:0] TK_LSS      = 6'd24;
  localparam logic [5:0] TK_LEQ      = 6'd25;
  localparam logic [5:0] TK_NEQ      = 6'd26;
  localparam logic [5:0] TK_GRT      = 6'd27;
  localparam logic [5:0] TK_GEQ      = 6'd28;
  localparam logic [5:0] TK_LPAREN   = 6'd29;
  localparam logic [5:0] TK_RPAREN   = 6'd30;
  localparam logic [5:0] TK_PERIOD   = 6'd31;
  localparam logic [5:0] TK_COMMA    = 6'd32;
  localparam logic [5:0] TK_SEMI     = 6'd33;
  localparam logic [5:0] TK_LBRACK   = 6'd34;
  localparam logic [5:0] TK_RBRACK   = 6'd35;
  localparam logic [5:0] TK_ASSIGN   = 6'd36;

  localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;

  // Keyword text, first character in the lowest byte; long ones cut to 8
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_004E_4947_4542,  // BEGIN
    64'h0000_0000_4C4C_4143,  // CALL
    64'h0000_0054_534E_4F43,  // CONST
    64'h0000_0000_0000_4F44,  // DO
    64'h0000_0000_4553_4C45,  // ELSE
    64'h0000_0000_0044_4E45,  // END
    64'h0000_0000_0052_4F46,  // FOR
    64'h0000_0000_0000_4649,  // IF
    64'h0000_0000_0044_444F,  // ODD
    64'h5255_4445_434F_5250,  // PROCEDURE
    64'h004D_4152_474F_5250,  // PROGRAM
    64'h0000_0000_4E45_4854,  // THEN
    64'h0000_0000_0000_4F54,  // TO
    64'h0000_0000_0052_4156,  // VAR
    64'h0000_0045_4C49_4857   // WHILE
  };

  // Full keyword lengths; a keyword longer than the stored text never matches
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd4, 4'd5, 4'd2, 4'd4, 4'd3, 4'd3, 4'd2,
    4'd3, 4'd9, 4'd7, 4'd4, 4'd2, 4'd3, 4'd5
  };

  // One result word
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [30:0] number_value;
    logic        number_overflow;
    logic [63:0] ident_text;
    logic [3:0]  ident_length;
    logic        last_of_run;
  } result_t;

  // Results made by one scan step, packed from res0
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

[hw/rtl/pl0lex_kw_match.sv]
// Keyword matcher: compares the stored identifier against the keyword table.
// Depends on pl0lex_pkg.
module pl0lex_kw_match (
  input  logic [63:0] ident_text,
  input  logic [3:0]  ident_length,
  output logic [5:0]  token_kind
);

  logic found;

  // Compare all keywords in parallel, first hit wins
  always_comb begin
    found      = 1'b0;
    token_kind = pl0lex_pkg::TK_IDENT;
    for (int k = 0; k < pl0lex_pkg::KW_COUNT; k++) begin
      if (!found && ident_length == pl0lex_pkg::KW_LEN[k] &&
          ident_text == pl0lex_pkg::KW_TEXT[k]) begin
        found      = 1'b1;
        token_kind = 6'(pl0lex_pkg::TK_KW_FIRST + 6'(k));
      end
    end
  end

endmodule

[hw/rtl/pl0lex_scan.sv]
// Scanner core: token state registers and the per-character next-state logic.
// Depends on pl0lex_pkg and pl0lex_kw_match.
module pl0lex_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          char_code,
  input  logic                end_of_input,
  output pl0lex_pkg::push_t   push
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_LT,
    MODE_GT,
    MODE_COLON
  } mode_t;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  function automatic logic [5:0] single_op(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h2B:   k = pl0lex_pkg::TK_PLUS;
      8'h2D:   k = pl0lex_pkg::TK_MINUS;
      8'h2A:   k = pl0lex_pkg::TK_TIMES;
      8'h2F:   k = pl0lex_pkg::TK_SLASH;
      8'h25:   k = pl0lex_pkg::TK_PERCENT;
      8'h3D:   k = pl0lex_pkg::TK_EQL;
      8'h28:   k = pl0lex_pkg::TK_LPAREN;
      8'h29:   k = pl0lex_pkg::TK_RPAREN;
      8'h2E:   k = pl0lex_pkg::TK_PERIOD;
      8'h2C:   k = pl0lex_pkg::TK_COMMA;
      8'h3B:   k = pl0lex_pkg::TK_SEMI;
      8'h5B:   k = pl0lex_pkg::TK_LBRACK;
      8'h5D:   k = pl0lex_pkg::TK_RBRACK;
      default: k = pl0lex_pkg::TK_NONE;
    endcase
    return k;
  endfunction

  mode_t       mode, mode_next;
  logic [30:0] acc, acc_next;
  logic        ovf, ovf_next;
  logic [63:0] buffer, buffer_next;
  logic [3:0]  count, count_next;

  logic        is_digit, is_alpha, is_space;
  logic [7:0]  upper;
  logic [34:0] acc_prod;
  logic [5:0]  kw_kind;

  mode_t       fresh_mode;
  logic [30:0] fresh_acc;
  logic [63:0] fresh_buffer;
  logic [3:0]  fresh_count;
  logic        fresh_emit;

  pl0lex_pkg::result_t flush_res, r0, r1;
  logic                flush_valid, r0_valid, r1_valid;

  pl0lex_kw_match u_kw_match (
    .ident_text   (buffer),
    .ident_length (count),
    .token_kind   (kw_kind)
  );

  // Character classes
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_alpha = ((char_code >= 8'd65) && (char_code <= 8'd90)) ||
                    ((char_code >= 8'd97) && (char_code <= 8'd122));
  assign is_space = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                    (char_code == CH_NL);
  assign upper    = (char_code >= 8'd97 && char_code <= 8'd122) ?
                    char_code - 8'd32 : char_code;

  // Accumulate the next decimal digit: acc * 8 + acc * 2 + digit
  assign acc_prod = 35'({acc, 3'b000}) + 35'({acc, 1'b0}) +
                    35'(char_code - CH_ZERO);

  // Decode a character that starts a new token
  always_comb begin
    fresh_mode   = MODE_IDLE;
    fresh_acc    = '0;
    fresh_buffer = '0;
    fresh_count  = '0;
    fresh_emit   = 1'b0;
    priority if (is_space) begin
      fresh_mode = MODE_IDLE;
    end else if (is_digit) begin
      fresh_mode = MODE_NUM;
      fresh_acc  = 31'(char_code - CH_ZERO);
    end else if (is_alpha) begin
      fresh_mode   = MODE_IDENT;
      fresh_buffer = 64'(upper);
      fresh_count  = 4'd1;
    end else if (char_code == CH_LT) begin
      fresh_mode = MODE_LT;
    end else if (char_code == CH_GT) begin
      fresh_mode = MODE_GT;
    end else if (char_code == CH_COLON) begin
      fresh_mode = MODE_COLON;
    end else begin
      fresh_emit = 1'b1;
    end
  end

  // Token held in the state, as it reads when closed
  always_comb begin
    flush_res   = '0;
    flush_valid = (mode != MODE_IDLE);
    unique case (mode)
      MODE_NUM: begin
        flush_res.token_kind      = pl0lex_pkg::TK_NUMBER;
        flush_res.number_value    = acc;
        flush_res.number_overflow = ovf;
      end
      MODE_IDENT: begin
        flush_res.token_kind   = kw_kind;
        flush_res.ident_text   = buffer;
        flush_res.ident_length = count;
      end
      MODE_LT:    flush_res.token_kind = pl0lex_pkg::TK_LSS;
      MODE_GT:    flush_res.token_kind = pl0lex_pkg::TK_GRT;
      MODE_COLON: flush_res.token_kind = pl0lex_pkg::TK_NONE;
      default:    flush_res.token_kind = pl0lex_pkg::TK_NONE;
    endcase
  end

  // Next state and results for one character
  always_comb begin
    mode_next   = mode;
    acc_next    = acc;
    ovf_next    = ovf;
    buffer_next = buffer;
    count_next  = count;
    r0          = '0;
    r1          = '0;
    r0_valid    = 1'b0;
    r1_valid    = 1'b0;
    priority if (end_of_input) begin
      r0          = flush_res;
      r0_valid    = flush_valid;
      mode_next   = MODE_IDLE;
      acc_next    = '0;
      ovf_next    = 1'b0;
      buffer_next = '0;
      count_next  = '0;
    end else if (mode == MODE_NUM && is_digit) begin
      if (acc_prod > 35'(pl0lex_pkg::NUM_LIMIT)) begin
        acc_next = pl0lex_pkg::NUM_LIMIT;
        ovf_next = 1'b1;
      end else begin
        acc_next = acc_prod[30:0];
      end
    end else if (mode == MODE_IDENT && (is_digit || is_alpha)) begin
      // Drop characters past the stored length
      if (count < 4'(pl0lex_pkg::MAX_ID_CHARS)) begin
        for (int i = 0; i < pl0lex_pkg::MAX_ID_CHARS; i++) begin
          if (count == 4'(i)) begin
            buffer_next[8*i +: 8] = upper;
          end
        end
        count_next = count + 4'd1;
      end
    end else if (mode == MODE_LT && (char_code == CH_EQ || char_code == CH_GT)) begin
      r0.token_kind = (char_code == CH_EQ) ? pl0lex_pkg::TK_LEQ : pl0lex_pkg::TK_NEQ;
      r0_valid      = 1'b1;
      mode_next     = MODE_IDLE;
    end else if ((mode == MODE_GT || mode == MODE_COLON) && char_code == CH_EQ) begin
      r0.token_kind = (mode == MODE_GT) ? pl0lex_pkg::TK_GEQ : pl0lex_pkg::TK_ASSIGN;
      r0_valid      = 1'b1;
      mode_next     = MODE_IDLE;
    end else begin
      // Close any pending token, then start on this character
      r0            = flush_res;
      r0_valid      = flush_valid;
      mode_next     = fresh_mode;
      acc_next      = fresh_acc;
      ovf_next      = 1'b0;
      buffer_next   = fresh_buffer;
      count_next    = fresh_count;
      r1.token_kind = single_op(char_code);
      r1_valid      = fresh_emit;
    end
  end

  // Pack results from slot zero and mark the last one
  always_comb begin
    push.cnt              = 2'(r0_valid) + 2'(r1_valid);
    push.res0             = r0_valid ? r0 : r1;
    push.res0.last_of_run = !(r0_valid && r1_valid);
    push.res1             = r1;
    push.res1.last_of_run = 1'b1;
  end

  // Hold scanner state, advance on each stepped character
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      acc    <= '0;
      ovf    <= 1'b0;
      buffer <= '0;
      count  <= '0;
    end else if (step) begin
      mode   <= mode_next;
      acc    <= acc_next;
      ovf    <= ovf_next;
      buffer <= buffer_next;
      count  <= count_next;
    end
  end

endmodule

[hw/rtl/pl0lex_res_fifo.sv]
// Result queue: takes up to two results a cycle, hands out one per word.
// Depends on pl0lex_pkg and pl0_lexical_scanner_top_macros.svh.
`include "pl0_lexical_scanner_top_macros.svh"

module pl0lex_res_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  pl0lex_pkg::push_t     push,
  output logic                  room2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pl0lex_pkg::result_t   out_res
);

  localparam int PW = $clog2(pl0lex_pkg::RQ_DEPTH);
  localparam int CW = $clog2(pl0lex_pkg::RQ_DEPTH + 1);

  pl0lex_pkg::result_t entries [pl0lex_pkg::RQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= CW'(pl0lex_pkg::RQ_DEPTH - 2));

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      entries[PW'(wr_ptr + PW'(1))] <= push.res1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PW'(wr_ptr + PW'(push.cnt));
      rd_ptr <= PW'(rd_ptr + PW'(pop));
      count  <= CW'(count + CW'(push.cnt) - CW'(pop));
    end
  end

  `PL0_ASSERT(a_no_overrun, (push.cnt != 2'd0) |-> ((CW+1)'(count) + (CW+1)'(push.cnt) <= (CW+1)'(pl0lex_pkg::RQ_DEPTH)), "result queue overrun")
  `PL0_ASSERT(a_count_bound, count <= CW'(pl0lex_pkg::RQ_DEPTH), "result queue count out of range")
  `PL0_ASSERT(a_pair_last, (push.cnt == 2'd2) |-> (!push.res0.last_of_run && push.res1.last_of_run), "bad last flag on result pair")
  `PL0_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0), "queue not empty after reset")

endmodule

[hw/rtl/pl0_lexical_scanner_top.sv]
// A character is registered at accept, then scanned and its first token written to the
// result queue, which raises out_valid. Throughput: one character per cycle while each
// gives at most one token and the queue has room for two results; the output side moves
// one token per cycle while out_ready is high, so character pairs yielding two tokens
// run at the output rate, set by the four-entry result queue.
// Reset clears the input register's full flag and the scanner state and empties the result queue.
module pl0_lexical_scanner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [30:0] number_value,
  output logic        number_overflow,
  output logic [63:0] ident_text,
  output logic [3:0]  ident_length,
  output logic        last_of_run
);

  logic       in_full;
  logic [7:0] char_reg;
  logic       eoi_reg;
  logic       room2;
  logic       step;

  pl0lex_pkg::push_t   push_raw;
  pl0lex_pkg::push_t   push;
  pl0lex_pkg::result_t out_res;

  // Scan the held word once the queue can take two results
  assign step     = in_full && room2;
  assign in_ready = !in_full || step;

  // Hold the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_reg <= char_code;
      eoi_reg  <= end_of_input;
    end
  end

  pl0lex_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .char_code    (char_reg),
    .end_of_input (eoi_reg),
    .push         (push_raw)
  );

  // Drop results of a stalled step
  assign push = step ? push_raw : '0;

  pl0lex_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign token_kind      = out_res.token_kind;
  assign number_value    = out_res.number_value;
  assign number_overflow = out_res.number_overflow;
  assign ident_text      = out_res.ident_text;
  assign ident_length    = out_res.ident_length;
  assign last_of_run     = out_res.last_of_run;

endmodule

[tb/pl0_lexical_scanner_top_tb.sv]
// Self-checking testbench for the PL/0 character scanner top level.
// Depends on pl0lex_pkg for token codes and the result word layout; it drives
// characters with random gaps, stalls the token side and checks each token word.
module pl0_lexical_scanner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX   = 10;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_LT, SCAN_GT, SCAN_COLON
  } scan_state_t;

  typedef enum logic [1:0] {
    RX_OPEN, RX_BUSY_RARE, RX_BUSY_OFTEN, RX_PATTERN
  } rx_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  token_kind;
  logic [30:0] number_value;
  logic        number_overflow;
  logic [63:0] ident_text;
  logic [3:0]  ident_length;
  logic        last_of_run;

  pl0_lexical_scanner_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .number_value(number_value),
    .number_overflow(number_overflow), .ident_text(ident_text),
    .ident_length(ident_length), .last_of_run(last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Keyword spellings in token code order, starting at TK_KW_FIRST
  string kw_names [pl0lex_pkg::KW_COUNT] = '{
    "BEGIN", "CALL", "CONST", "DO", "ELSE", "END", "FOR", "IF", "ODD",
    "PROCEDURE", "PROGRAM", "THEN", "TO", "VAR", "WHILE"
  };

  // Scanner model state
  scan_state_t scan_state = SCAN_IDLE;
  logic [30:0] num_acc    = '0;
  logic        num_sat    = 1'b0;
  logic [63:0] word_text  = '0;
  logic [3:0]  word_len   = '0;

  pl0lex_pkg::result_t step_tokens [$];
  pl0lex_pkg::result_t pending_tokens [$];
  logic [7:0] lexeme [$];

  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  // ---------------------------------------------------------------- model

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd10;
  endfunction

  function automatic logic [7:0] upper_char(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    case (c)
      "+":     return pl0lex_pkg::TK_PLUS;
      "-":     return pl0lex_pkg::TK_MINUS;
      "*":     return pl0lex_pkg::TK_TIMES;
      "/":     return pl0lex_pkg::TK_SLASH;
      "%":     return pl0lex_pkg::TK_PERCENT;
      "=":     return pl0lex_pkg::TK_EQL;
      "(":     return pl0lex_pkg::TK_LPAREN;
      ")":     return pl0lex_pkg::TK_RPAREN;
      ".":     return pl0lex_pkg::TK_PERIOD;
      ",":     return pl0lex_pkg::TK_COMMA;
      ";":     return pl0lex_pkg::TK_SEMI;
      "[":     return pl0lex_pkg::TK_LBRACK;
      "]":     return pl0lex_pkg::TK_RBRACK;
      default: return pl0lex_pkg::TK_NONE;
    endcase
  endfunction

  // Match the stored word against the keywords; long keywords never match
  function automatic logic [5:0] word_kind();
    logic [63:0] kw_text;
    for (int k = 0; k < pl0lex_pkg::KW_COUNT; k++) begin
      kw_text = '0;
      for (int i = 0; i < kw_names[k].len() && i < 8; i++) begin
        kw_text[8*i +: 8] = kw_names[k][i];
      end
      if (kw_names[k].len() <= pl0lex_pkg::MAX_ID_CHARS &&
          kw_names[k].len() == word_len && kw_text == word_text) begin
        return pl0lex_pkg::TK_KW_FIRST + 6'(k);
      end
    end
    return pl0lex_pkg::TK_IDENT;
  endfunction

  function automatic void queue_token(logic [5:0] kind, logic [30:0] num, logic ovf,
                                      logic [63:0] text, logic [3:0] len);
    pl0lex_pkg::result_t r;
    r.token_kind      = kind;
    r.number_value    = num;
    r.number_overflow = ovf;
    r.ident_text      = text;
    r.ident_length    = len;
    r.last_of_run     = 1'b0;
    step_tokens.push_back(r);
  endfunction

  // Emit whatever token is pending and return to idle
  function automatic void close_token();
    case (scan_state)
      SCAN_NUM:   queue_token(pl0lex_pkg::TK_NUMBER, num_acc, num_sat, '0, '0);
      SCAN_WORD:  queue_token(word_kind(), '0, 1'b0, word_text, word_len);
      SCAN_LT:    queue_token(pl0lex_pkg::TK_LSS, '0, 1'b0, '0, '0);
      SCAN_GT:    queue_token(pl0lex_pkg::TK_GRT, '0, 1'b0, '0, '0);
      SCAN_COLON: queue_token(pl0lex_pkg::TK_NONE, '0, 1'b0, '0, '0);
      default: ;
    endcase
    scan_state = SCAN_IDLE;
    num_acc    = '0;
    num_sat    = 1'b0;
    word_text  = '0;
    word_len   = '0;
  endfunction

  // Start a token from idle
  function automatic void open_token(logic [7:0] c);
    if (is_blank(c)) begin
      return;
    end
    if (is_digit(c)) begin
      scan_state = SCAN_NUM;
      num_acc    = 31'(c - "0");
      num_sat    = 1'b0;
    end else if (is_alpha(c)) begin
      scan_state = SCAN_WORD;
      word_text  = 64'(upper_char(c));
      word_len   = 4'd1;
    end else if (c == "<") begin
      scan_state = SCAN_LT;
    end else if (c == ">") begin
      scan_state = SCAN_GT;
    end else if (c == ":") begin
      scan_state = SCAN_COLON;
    end else begin
      queue_token(op_kind(c), '0, 1'b0, '0, '0);
    end
  endfunction

  // Advance the scanner model by one accepted word and queue its tokens
  function automatic void scan_char(logic [7:0] c, logic eoi);
    longint unsigned v;
    pl0lex_pkg::result_t r;
    step_tokens.delete();
    if (eoi) begin
      close_token();
    end else begin
      case (scan_state)
        SCAN_NUM: begin
          if (is_digit(c)) begin
            v = 64'(num_acc) * 10 + 64'(c - "0");
            if (v > 64'(pl0lex_pkg::NUM_LIMIT)) begin
              v = 64'(pl0lex_pkg::NUM_LIMIT);
              num_sat = 1'b1;
            end
            num_acc = v[30:0];
          end else begin
            close_token();
            open_token(c);
          end
        end
        SCAN_WORD: begin
          if (is_digit(c) || is_alpha(c)) begin
            if (word_len < pl0lex_pkg::MAX_ID_CHARS) begin
              word_text[8*word_len +: 8] = upper_char(c);
              word_len++;
            end
          end else begin
            close_token();
            open_token(c);
          end
        end
        SCAN_LT: begin
          if (c == "=" || c == ">") begin
            scan_state = SCAN_IDLE;
            queue_token((c == "=") ? pl0lex_pkg::TK_LEQ : pl0lex_pkg::TK_NEQ,
                        '0, 1'b0, '0, '0);
          end else begin
            close_token();
            open_token(c);
          end
        end
        SCAN_GT, SCAN_COLON: begin
          if (c == "=") begin
            queue_token((scan_state == SCAN_GT) ? pl0lex_pkg::TK_GEQ :
                        pl0lex_pkg::TK_ASSIGN, '0, 1'b0, '0, '0);
            scan_state = SCAN_IDLE;
          end else begin
            close_token();
            open_token(c);
          end
        end
        default: begin
          open_token(c);
        end
      endcase
    end
    // Flag the final token of this word
    if (step_tokens.size() > 0) begin
      r = step_tokens.pop_back();
      r.last_of_run = 1'b1;
      step_tokens.push_back(r);
    end
    foreach (step_tokens[i]) begin
      pending_tokens.push_back(step_tokens[i]);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      report_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    end
  endfunction

  function automatic void check_token();
    pl0lex_pkg::result_t want;
    if (pending_tokens.size() == 0) begin
      report_error($sformatf("token kind %0d arrived with none expected", token_kind));
    end else begin
      want = pending_tokens.pop_front();
      compare_field("token_kind", 64'(want.token_kind), 64'(token_kind));
      compare_field("number_value", 64'(want.number_value), 64'(number_value));
      compare_field("number_overflow", 64'(want.number_overflow), 64'(number_overflow));
      compare_field("ident_text", want.ident_text, ident_text);
      compare_field("ident_length", 64'(want.ident_length), 64'(ident_length));
      compare_field("last_of_run", 64'(want.last_of_run), 64'(last_of_run));
    end
  endfunction

  // Predict on accepted input words, then check accepted token words
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        scan_char(char_code, end_of_input);
      end
      if (out_valid && out_ready) begin
        check_token();
      end
    end
  end

  // Stall the token side in changing styles
  rx_style_t   ready_style = RX_OPEN;
  int unsigned ready_left  = 0;
  logic [7:0]  ready_mask  = 8'b1011_0010;

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_style = rx_style_t'($urandom_range(0, 3));
      ready_left  = $urandom_range(16, 96);
      ready_mask  = 8'($urandom_range(1, 255));
    end
    ready_left--;
    ready_mask = {ready_mask[6:0], ready_mask[7]};
    case (ready_style)
      RX_OPEN:       out_ready <= 1'b1;
      RX_BUSY_RARE:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_BUSY_OFTEN: out_ready <= ($urandom_range(0, 3) == 0);
      default:       out_ready <= ready_mask[0];
    endcase
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  task automatic pause_sender(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Send one word; open a new burst after a random gap when the last one ran out
  task automatic send_word(logic [7:0] c, logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        pause_sender(gap);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    char_code    <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b0);
    end
  endtask

  // Hold the sender until every expected token has come out
  task automatic wait_idle();
    pause_sender(1);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    return (is_alpha(c) && $urandom_range(0, 1)) ? c ^ 8'h20 : c;
  endfunction

  function automatic logic [7:0] random_alnum();
    int unsigned pick;
    pick = $urandom_range(0, 61);
    if (pick < 10) begin
      return 8'("0") + 8'(pick);
    end else if (pick < 36) begin
      return 8'("A") + 8'(pick - 10);
    end
    return 8'("a") + 8'(pick - 36);
  endfunction

  function automatic logic is_known(logic [7:0] c);
    return is_digit(c) || is_alpha(c) || is_blank(c) ||
           op_kind(c) != pl0lex_pkg::TK_NONE || c == "<" || c == ">" || c == ":";
  endfunction

  // Build one well-formed lexeme with random content
  function automatic void build_lexeme();
    int unsigned pick;
    int unsigned n;
    string s;
    string ops;
    string pairs [7];
    logic [7:0] c;
    ops   = "+-*/%=().,;[]";
    pairs = '{"<=", "<>", ">=", ":=", "<", ">", ":"};
    s = "";
    lexeme.delete();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      s = kw_names[$urandom_range(0, pl0lex_pkg::KW_COUNT - 1)];
      for (int i = 0; i < s.len(); i++) begin
        lexeme.push_back(mixed_case(s[i]));
      end
    end else if (pick < 38) begin
      n = $urandom_range(1, 12);
      lexeme.push_back(mixed_case(8'("A") + 8'($urandom_range(0, 25))));
      for (int i = 1; i < n; i++) begin
        lexeme.push_back(random_alnum());
      end
    end else begin
      if (pick < 58) begin
        case ($urandom_range(0, 5))
          0:       s = "0";
          1:       s = "2147483647";
          2:       s = "2147483648";
          3:       s = $sformatf("%0d%0d", $urandom, $urandom);
          4:       s = $sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF));
          default: s = $sformatf("%0d", $urandom_range(0, 99999));
        endcase
      end else if (pick < 75) begin
        s = ops.substr(0, 0);
        n = $urandom_range(0, ops.len() - 1);
        s = ops.substr(n, n);
      end else if (pick < 88) begin
        s = pairs[$urandom_range(0, 6)];
      end
      for (int i = 0; i < s.len(); i++) begin
        lexeme.push_back(s[i]);
      end
      // Unknown byte, high half included
      if (pick >= 88) begin
        do begin
          c = 8'($urandom_range(0, 255));
        end while (is_known(c));
        lexeme.push_back(c);
      end
    end
  endfunction

  // Send a lexeme, then a separator, nothing, or an end-of-input flush
  task automatic send_lexeme();
    int unsigned pick;
    logic [7:0] blanks [3];
    blanks = '{8'd32, 8'd9, 8'd10};
    build_lexeme();
    foreach (lexeme[i]) begin
      send_word(lexeme[i], 1'b0);
    end
    pick = $urandom_range(0, 19);
    if (pick >= 8 && pick < 17) begin
      repeat ($urandom_range(1, 3)) send_word(blanks[$urandom_range(0, 2)], 1'b0);
    end else if (pick >= 17) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Byte extremes, saturation, lone colon, two-word operators and end flushes
  task automatic test_directed();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("2147483648");
    send_text(":x>=");
    send_word(8'h00, 1'b1);
    send_text("<");
    send_word(8'h00, 1'b1);
    send_text(">");
    send_word(8'hFF, 1'b1);
    wait_idle();
  endtask

  // Random token stream of keywords, names, numbers, operators and unknown bytes
  task automatic test_token_stream(int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) begin
      send_lexeme();
    end
  endtask

  // Random bytes with occasional end of input
  task automatic test_noise(int unsigned count);
    repeat (count) begin
      send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
    end
    send_word(8'h00, 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_token_stream(240);
    wait_idle();
    test_token_stream(240);
    wait_idle();
    test_noise(120);
    wait_idle();

    if (pending_tokens.size() != 0) begin
      report_error($sformatf("%0d expected tokens never arrived", pending_tokens.size()));
    end
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pl0lex_pkg.sv
hw/rtl/pl0lex_kw_match.sv
hw/rtl/pl0lex_scan.sv
hw/rtl/pl0lex_res_fifo.sv
hw/rtl/pl0_lexical_scanner_top.sv
tb/pl0_lexical_scanner_top_tb.sv
